// ===== hw/rtl/bdm_pkg.sv =====
// Shared types and constants for the button debounce and multi-click block.
package bdm_pkg;

  localparam int unsigned TIME_MS_W      = 32;
  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned CFG_MS_W       = 16;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned COUNT_W        = 8;
  localparam int unsigned KIND_W         = 2;

  localparam logic [CFG_MS_W-1:0] DEBOUNCE_MS_RST   = 16'd50;
  localparam logic [CFG_MS_W-1:0] MULTICLICK_MS_RST = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_MULTICLICK = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_LOW      = 3'd0,
    PH_DEB_UP   = 3'd1,
    PH_HIGH     = 3'd2,
    PH_LONG     = 3'd3,
    PH_DEB_DOWN = 3'd4
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    EV_LOW   = 2'd0,
    EV_HIGH  = 2'd1,
    EV_LONG  = 2'd2,
    EV_MULTI = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [CFG_MS_W-1:0] debounce_ms;
    logic [CFG_MS_W-1:0] multiclick_ms;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    ev_kind_t             kind;
    logic [COUNT_W-1:0]   count;
    logic [TIME_MS_W-1:0] time_ms;
  } event_t;

endpackage

// ===== hw/rtl/bdm_ifs.sv =====
// Valid/ready channel interfaces for pin samples and button events.
interface bdm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          pin_level;
  logic [bdm_pkg::TIME_MS_W-1:0] time_ms;

  modport source (output valid, output pin_level, output time_ms, input ready);
  modport sink (input valid, input pin_level, input time_ms, output ready);
endinterface

interface bdm_out_if;
  logic                          valid;
  logic                          ready;
  logic [bdm_pkg::KIND_W-1:0]    event_kind;
  logic [bdm_pkg::COUNT_W-1:0]   event_count;
  logic [bdm_pkg::TIME_MS_W-1:0] event_time;

  modport source (output valid, output event_kind, output event_count, output event_time,
                  input ready);
  modport sink (input valid, input event_kind, input event_count, input event_time,
                output ready);
endinterface

// ===== hw/rtl/bdm_cfg_regs.sv =====
// Configuration registers for debounce time and multi-click delay.
module bdm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdm_pkg::CFG_MS_W-1:0]   cfg_data,
  output bdm_pkg::cfg_t                  cfg
);

  bdm_pkg::cfg_t cfg_r;
  bdm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (bdm_pkg::cfg_idx_t'(cfg_index))
        bdm_pkg::CFG_DEBOUNCE:   cfg_nxt.debounce_ms   = cfg_data;
        bdm_pkg::CFG_MULTICLICK: cfg_nxt.multiclick_ms = cfg_data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= bdm_pkg::DEBOUNCE_MS_RST;
      cfg_r.multiclick_ms <= bdm_pkg::MULTICLICK_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/bdm_fsm.sv =====
// Phase machine that debounces the pin and detects presses, long presses and multi-clicks.
module bdm_fsm #(
  parameter int unsigned TIME_WIDTH = bdm_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic                  level,
  input  logic [TIME_WIDTH-1:0] now,
  input  bdm_pkg::cfg_t         cfg,
  output bdm_pkg::event_t       ev
);

  bdm_pkg::phase_t               phase_r, phase_nxt;
  logic                          last_level_r, last_level_nxt;
  logic [bdm_pkg::COUNT_W-1:0]   press_count_r, press_count_nxt;
  logic [TIME_WIDTH-1:0]         debounce_start_r, debounce_start_nxt;
  logic [TIME_WIDTH-1:0]         click_start_r, click_start_nxt;

  logic                          edge_ok;
  logic                          rise;
  logic                          fall;
  logic [TIME_WIDTH-1:0]         el_deb;
  logic [TIME_WIDTH-1:0]         el_click;
  logic                          deb_done;
  logic                          click_over;
  logic [bdm_pkg::COUNT_W-1:0]   count_inc;

  assign edge_ok    = (phase_r != bdm_pkg::PH_DEB_UP) && (phase_r != bdm_pkg::PH_DEB_DOWN);
  assign rise       = edge_ok && level && !last_level_r;
  assign fall       = edge_ok && !level && last_level_r;
  assign el_deb     = now - debounce_start_r;
  assign el_click   = now - click_start_r;
  assign deb_done   = el_deb >= TIME_WIDTH'(cfg.debounce_ms);
  assign click_over = el_click > TIME_WIDTH'(cfg.multiclick_ms);
  assign count_inc  = press_count_r + bdm_pkg::COUNT_W'(1);

  always_comb begin
    phase_nxt          = phase_r;
    last_level_nxt     = edge_ok ? level : last_level_r;
    press_count_nxt    = press_count_r;
    debounce_start_nxt = debounce_start_r;
    click_start_nxt    = click_start_r;
    ev.valid           = 1'b0;
    ev.kind            = bdm_pkg::EV_LOW;
    ev.count           = '0;
    ev.time_ms         = bdm_pkg::TIME_MS_W'(now);
    unique case (phase_r)
      bdm_pkg::PH_DEB_DOWN: begin
        if (deb_done) begin
          phase_nxt = bdm_pkg::PH_LOW;
          ev.valid  = 1'b1;
          ev.kind   = bdm_pkg::EV_LOW;
        end
      end
      bdm_pkg::PH_LOW: begin
        if ((press_count_r != '0) && click_over) begin
          ev.valid        = 1'b1;
          ev.kind         = bdm_pkg::EV_MULTI;
          ev.count        = press_count_r;
          press_count_nxt = '0;
        end
        if (rise) begin
          phase_nxt          = bdm_pkg::PH_DEB_UP;
          debounce_start_nxt = now;
        end
      end
      bdm_pkg::PH_DEB_UP: begin
        if (deb_done) begin
          phase_nxt       = bdm_pkg::PH_HIGH;
          click_start_nxt = now;
          press_count_nxt = count_inc;
          ev.valid        = 1'b1;
          ev.kind         = bdm_pkg::EV_HIGH;
          ev.count        = count_inc;
        end
      end
      bdm_pkg::PH_HIGH: begin
        if (click_over) begin
          phase_nxt       = bdm_pkg::PH_LONG;
          press_count_nxt = '0;
          ev.valid        = 1'b1;
          ev.kind         = bdm_pkg::EV_LONG;
        end else if (fall) begin
          phase_nxt          = bdm_pkg::PH_DEB_DOWN;
          debounce_start_nxt = now;
        end
      end
      bdm_pkg::PH_LONG: begin
        if (fall) begin
          phase_nxt          = bdm_pkg::PH_DEB_DOWN;
          debounce_start_nxt = now;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= bdm_pkg::PH_LOW;
      last_level_r     <= 1'b0;
      press_count_r    <= '0;
      debounce_start_r <= '0;
      click_start_r    <= '0;
    end else if (step_en) begin
      phase_r          <= phase_nxt;
      last_level_r     <= last_level_nxt;
      press_count_r    <= press_count_nxt;
      debounce_start_r <= debounce_start_nxt;
      click_start_r    <= click_start_nxt;
    end
  end

endmodule

// ===== hw/rtl/button_debounce_multiclick_core.sv =====
// Top level of the push-button debouncer with multi-click and long-press detection.
// Usage: each transaction on in_chan carries one raw pin sample and the current
// millisecond time. Results leave on out_chan as events: confirmed low, confirmed
// high with the press count, long press, or multi-click with the press count.
// A sample causes at most one event; samples that cause none produce no transaction.
// The cfg port writes the debounce time (index 0) and the multi-click delay
// (index 1); it should only be written while no sample is in flight.
// Path: a sample accepted on in_chan is held in an input register, processed by the
// phase machine once the output register is free, and its event is then offered
// on out_chan from the output register.
// Throughput: one sample per cycle while out_chan is not stalled, set by the single
// processing step between the input register and the output register.
// Reset: rst_n is synchronous and active low; it empties both registers, puts
// the machine in the confirmed low phase with no presses counted, and restores
// a debounce time of 50 ms and a multi-click delay of 500 ms.
// Stall: while out_chan is stalled with an event waiting, one more sample is
// held in the input register and in_chan then deasserts ready.
module button_debounce_multiclick_core #(
  parameter int unsigned TIME_WIDTH = bdm_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bdm_in_if.sink                        in_chan,
  bdm_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [bdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdm_pkg::CFG_MS_W-1:0]  cfg_data
);

  bdm_pkg::cfg_t                 cfg;
  bdm_pkg::event_t               ev;

  logic                          s1_vld_r, s1_vld_nxt;
  logic                          s1_level_r;
  logic [bdm_pkg::TIME_MS_W-1:0] s1_time_r;
  logic                          out_vld_r, out_vld_nxt;
  bdm_pkg::event_t               out_ev_r;

  logic                          out_free;
  logic                          step;
  logic                          in_acc;

  assign out_free = !out_vld_r || out_chan.ready;
  assign step     = s1_vld_r && out_free;
  assign in_chan.ready = !s1_vld_r || out_free;
  assign in_acc   = in_chan.valid && in_chan.ready;

  bdm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdm_fsm #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .level   (s1_level_r),
    .now     (TIME_WIDTH'(s1_time_r)),
    .cfg     (cfg),
    .ev      (ev)
  );

  always_comb begin
    s1_vld_nxt = in_acc ? 1'b1 : (step ? 1'b0 : s1_vld_r);
    if (step && ev.valid) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_level_r <= in_chan.pin_level;
      s1_time_r  <= in_chan.time_ms;
    end
    if (step && ev.valid) begin
      out_ev_r <= ev;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.event_kind  = out_ev_r.kind;
  assign out_chan.event_count = out_ev_r.count;
  assign out_chan.event_time  = out_ev_r.time_ms;

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && ((out_ev_r.kind == bdm_pkg::EV_LOW) || (out_ev_r.kind == bdm_pkg::EV_LONG))
    |-> (out_ev_r.count == '0))
    else $error("low or long-press event carries a non-zero count");

  a_multi_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_ev_r.kind == bdm_pkg::EV_MULTI) |-> (out_ev_r.count != '0))
    else $error("multi-click event with no presses");

  a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_vld_r))
    else $error("event produced without a sample in the input register");

  a_hold_sample: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !out_free |=> s1_vld_r && $stable(s1_time_r))
    else $error("held sample lost while the output was stalled");

endmodule

// ===== verif/button_debounce_multiclick_core_tb.sv =====
// Self-checking testbench for the push-button debouncer with multi-click and long-press events.
module button_debounce_multiclick_core_tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct {
    bdm_pkg::ev_kind_t                kind;
    logic [bdm_pkg::COUNT_W-1:0]      count;
    logic [bdm_pkg::TIME_MS_W-1:0]    stamp;
  } button_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [bdm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bdm_pkg::CFG_MS_W-1:0] cfg_data;

  bdm_in_if in_chan ();
  bdm_out_if out_chan ();

  button_debounce_multiclick_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Own copy of the button state and settings.
  bdm_pkg::phase_t               btn_phase;
  logic                          seen_level;
  logic [bdm_pkg::COUNT_W-1:0]   click_count;
  logic [bdm_pkg::TIME_MS_W-1:0] settle_start;
  logic [bdm_pkg::TIME_MS_W-1:0] press_start;
  logic [bdm_pkg::CFG_MS_W-1:0]  settle_ms;
  logic [bdm_pkg::CFG_MS_W-1:0]  click_gap_ms;

  button_event_t pending_events[$];
  int unsigned   errors = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   hold_left = 0;
  bit            gaps_on = 1'b1;
  logic [bdm_pkg::TIME_MS_W-1:0] now_ms = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit predict_button_event(input logic level,
                                              input logic [bdm_pkg::TIME_MS_W-1:0] now,
                                              output button_event_t ev);
    logic rise;
    logic fall;
    bit   fired;
    logic [bdm_pkg::TIME_MS_W-1:0] settle_age;
    logic [bdm_pkg::TIME_MS_W-1:0] press_age;
    rise = 1'b0;
    fall = 1'b0;
    fired = 1'b0;
    ev = '{bdm_pkg::EV_LOW, '0, now};
    settle_age = now - settle_start;
    press_age = now - press_start;
    if (btn_phase != bdm_pkg::PH_DEB_UP && btn_phase != bdm_pkg::PH_DEB_DOWN &&
        level != seen_level) begin
      rise = level;
      fall = !level;
      seen_level = level;
    end
    case (btn_phase)
      bdm_pkg::PH_DEB_DOWN: begin
        if (settle_age >= {16'd0, settle_ms}) begin
          btn_phase = bdm_pkg::PH_LOW;
          fired = 1'b1;
        end
      end
      bdm_pkg::PH_LOW: begin
        if (click_count != 0 && press_age > {16'd0, click_gap_ms}) begin
          ev.kind = bdm_pkg::EV_MULTI;
          ev.count = click_count;
          fired = 1'b1;
          click_count = '0;
        end
        if (rise) begin
          btn_phase = bdm_pkg::PH_DEB_UP;
          settle_start = now;
        end
      end
      bdm_pkg::PH_DEB_UP: begin
        if (settle_age >= {16'd0, settle_ms}) begin
          btn_phase = bdm_pkg::PH_HIGH;
          press_start = now;
          click_count = click_count + 1'b1;
          ev.kind = bdm_pkg::EV_HIGH;
          ev.count = click_count;
          fired = 1'b1;
        end
      end
      bdm_pkg::PH_HIGH: begin
        if (press_age > {16'd0, click_gap_ms}) begin
          btn_phase = bdm_pkg::PH_LONG;
          ev.kind = bdm_pkg::EV_LONG;
          fired = 1'b1;
          click_count = '0;
        end else if (fall) begin
          btn_phase = bdm_pkg::PH_DEB_DOWN;
          settle_start = now;
        end
      end
      bdm_pkg::PH_LONG: begin
        if (fall) begin
          btn_phase = bdm_pkg::PH_DEB_DOWN;
          settle_start = now;
        end
      end
      default: begin
      end
    endcase
    return fired;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [bdm_pkg::TIME_MS_W-1:0] time_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'd1;
      2: return {16'd0, settle_ms};
      3: return {16'd0, settle_ms} - 32'd1;
      4: return {16'd0, click_gap_ms};
      5: return {16'd0, click_gap_ms} + 32'd1;
      6: return $urandom_range(0, 2 * settle_ms + 2);
      default: return $urandom_range(0, 30);
    endcase
  endfunction

  task automatic send_sample(input logic level, input logic [bdm_pkg::TIME_MS_W-1:0] stamp);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.pin_level <= level;
    in_chan.time_ms   <= stamp;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input bdm_pkg::cfg_idx_t idx,
                           input logic [bdm_pkg::CFG_MS_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bdm_pkg::CFG_DEBOUNCE:   settle_ms = value;
      bdm_pkg::CFG_MULTICLICK: click_gap_ms = value;
      default: begin
      end
    endcase
  endtask

  task automatic test_single_click();
    send_sample(1'b1, 32'd1000);
    send_sample(1'b1, 32'd1049);
    send_sample(1'b1, 32'd1050);
    send_sample(1'b0, 32'd1100);
    send_sample(1'b0, 32'd1150);
    send_sample(1'b0, 32'd1650);
  endtask

  task automatic test_long_press();
    send_sample(1'b1, 32'd2000);
    send_sample(1'b1, 32'd2050);
    send_sample(1'b1, 32'd2550);
    send_sample(1'b1, 32'd2551);
    send_sample(1'b0, 32'd2600);
    send_sample(1'b0, 32'd2650);
  endtask

  task automatic test_release_at_long_press();
    send_sample(1'b1, 32'd3000);
    send_sample(1'b1, 32'd3050);
    send_sample(1'b0, 32'd3551);
    send_sample(1'b0, 32'd3600);
    send_sample(1'b1, 32'd3700);
    send_sample(1'b0, 32'd3800);
    send_sample(1'b0, 32'd3850);
  endtask

  // Zero debounce across the time wrap, then a quiet timeout on a rising sample
  // and a falling level hidden inside the debounce phase.
  task automatic test_wrap_and_zero_debounce();
    wait_drained();
    write_reg(bdm_pkg::CFG_DEBOUNCE, 16'd0);
    write_reg(bdm_pkg::CFG_MULTICLICK, 16'd100);
    send_sample(1'b1, 32'hFFFF_FFF0);
    send_sample(1'b1, 32'hFFFF_FFF0);
    send_sample(1'b0, 32'd5);
    send_sample(1'b0, 32'd5);
    send_sample(1'b1, 32'd200);
    send_sample(1'b0, 32'd200);
    send_sample(1'b0, 32'd201);
    send_sample(1'b0, 32'd202);
    now_ms = 32'd202;
  endtask

  task automatic test_count_overflow();
    wait_drained();
    write_reg(bdm_pkg::CFG_DEBOUNCE, 16'd0);
    write_reg(bdm_pkg::CFG_MULTICLICK, 16'hFFFF);
    now_ms += 32'd70000;
    send_sample(1'b0, now_ms);
    // The receiver holds off while the presses start, so the block backs up.
    hold_left = 200;
    for (int p = 0; p < 258; p++) begin
      if (p % 32 == 0) gaps_on = $urandom_range(0, 2) != 0;
      if (p == 128) wait_drained();
      now_ms += $urandom_range(0, 20);
      send_sample(1'b1, now_ms);
      now_ms += $urandom_range(0, 20);
      send_sample(1'($urandom_range(0, 1)), now_ms);
      now_ms += $urandom_range(0, 20);
      send_sample(1'b0, now_ms);
      now_ms += $urandom_range(0, 20);
      send_sample(1'($urandom_range(0, 1)), now_ms);
      if (p == 255 || p == 257) begin
        now_ms += 32'd70000;
        send_sample(1'b0, now_ms);
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_config_sweep();
    logic [bdm_pkg::CFG_MS_W-1:0] deb;
    logic [bdm_pkg::CFG_MS_W-1:0] gap;
    logic lvl;
    int unsigned sent;
    int unsigned run;
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: begin deb = 16'd0;     gap = 16'd0;     end
        1: begin deb = 16'd0;     gap = 16'hFFFF;  end
        2: begin deb = 16'hFFFF;  gap = 16'hFFFF;  end
        3: begin deb = bdm_pkg::DEBOUNCE_MS_RST; gap = bdm_pkg::MULTICLICK_MS_RST; end
        4: begin deb = 16'd1;     gap = 16'd3;     end
        5: begin deb = 16'hFFFF;  gap = 16'd0;     end
        default: begin
          deb = 16'($urandom_range(0, 200));
          gap = 16'($urandom_range(0, 2000));
        end
      endcase
      wait_drained();
      write_reg(bdm_pkg::CFG_DEBOUNCE, deb);
      write_reg(bdm_pkg::CFG_MULTICLICK, gap);
      gaps_on = (k % 3) != 1;
      sent = 0;
      lvl = 1'b1;
      while (sent < 60) begin
        if ($urandom_range(0, 9) == 0) begin
          now_ms = $urandom();
          send_sample(1'($urandom_range(0, 1)), now_ms);
          sent++;
        end else begin
          run = $urandom_range(1, 4);
          repeat (run) begin
            now_ms += time_step();
            send_sample(lvl, now_ms);
            sent++;
          end
          if ($urandom_range(0, 7) == 0) begin
            now_ms += time_step();
            send_sample(!lvl, now_ms);
            sent++;
          end
          lvl = !lvl;
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    button_event_t ev;
    button_event_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event kind=%0d count=%0d time=%0h", $time,
                   out_chan.event_kind, out_chan.event_count, out_chan.event_time);
          errors++;
        end else begin
          want = pending_events.pop_front();
          if (out_chan.event_kind !== want.kind) begin
            $display("%0t: event_kind expected %0d, got %0d", $time, want.kind,
                     out_chan.event_kind);
            errors++;
          end
          if (out_chan.event_count !== want.count) begin
            $display("%0t: event_count expected %0d, got %0d", $time, want.count,
                     out_chan.event_count);
            errors++;
          end
          if (out_chan.event_time !== want.stamp) begin
            $display("%0t: event_time expected %0h, got %0h", $time, want.stamp,
                     out_chan.event_time);
            errors++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        if (predict_button_event(in_chan.pin_level, in_chan.time_ms, ev)) begin
          pending_events.push_back(ev);
        end
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("** button_debounce_multiclick_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.pin_level = 1'b0;
    in_chan.time_ms = '0;
    cfg_we = 1'b0;
    cfg_index = bdm_pkg::CFG_DEBOUNCE;
    cfg_data = '0;
    btn_phase = bdm_pkg::PH_LOW;
    seen_level = 1'b0;
    click_count = '0;
    settle_start = '0;
    press_start = '0;
    settle_ms = bdm_pkg::DEBOUNCE_MS_RST;
    click_gap_ms = bdm_pkg::MULTICLICK_MS_RST;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_single_click();
    test_long_press();
    test_release_at_long_press();
    test_wrap_and_zero_debounce();
    test_count_overflow();
    test_config_sweep();

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("** button_debounce_multiclick_core: PASSED **");
    end else begin
      $display("** button_debounce_multiclick_core: FAILED **");
    end
    $finish;
  end

endmodule
